// ===== rtl/byte_run_length_encoder_unit_defines.svh =====
// assertion macros for the byte run-length encoder unit
// depends on: nothing; users provide clk_i and rst_ni in scope
`ifndef BYTE_RUN_LENGTH_ENCODER_UNIT_DEFINES_SVH
`define BYTE_RUN_LENGTH_ENCODER_UNIT_DEFINES_SVH

// condition holds at every clock edge out of reset
`define BRLE_ASSERT_NOW(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("brle assertion failed");

// antecedent at one edge implies consequent at the next edge
`define BRLE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("brle assertion failed");

`endif

// ===== rtl/brle_pkg.sv =====
// shared types and constants of the byte run-length encoder unit
// depends on: nothing
package brle_pkg;

  // row size limit and field widths
  localparam int ROW_BYTES   = 4096;
  localparam int OFF_W       = 13;
  localparam int SEEN_W      = $clog2(ROW_BYTES + 2);
  localparam int MAX_RESULTS = 6;
  localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // encoding constants
  localparam logic [6:0] RUN_CAP    = 7'd120;
  localparam logic [6:0] RUN_MIN    = 7'd3;
  localparam logic [7:0] TOKEN_FLAG = 8'h80;

  // input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       row_end;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [OFF_W-1:0] write_offset;
    logic [7:0]       write_byte;
    logic             last_of_item;
    logic             row_done;
    logic [OFF_W-1:0] row_length;
    logic             overlong;
  } out_item_t;

  // one addressed write
  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic [7:0]       value;
  } wr_t;

  // encoder state carried between items
  typedef struct packed {
    logic [7:0]        pending_value;
    logic [6:0]        pending_run;
    logic [6:0]        literal_count;
    logic [OFF_W-1:0]  count_slot;
    logic [OFF_W-1:0]  fill_position;
    logic [SEEN_W-1:0] bytes_seen;
  } enc_state_t;

  localparam enc_state_t ENC_RESET = '{
    pending_value: 8'd0,
    pending_run:   7'd0,
    literal_count: 7'd0,
    count_slot:    '0,
    fill_position: OFF_W'(1),
    bytes_seen:    '0
  };

  // all writes caused by one item plus item-level flags
  typedef struct packed {
    wr_t [MAX_RESULTS-1:0] writes;
    logic [RES_CNT_W-1:0]  count;
    logic                  overlong;
    logic                  row_end;
    logic [OFF_W-1:0]      row_length;
  } step_out_t;

endpackage

// ===== rtl/brle_in_if.sv =====
// valid/ready channel carrying one uncompressed input item
// depends on: brle_pkg
interface brle_in_if;
  logic                valid;
  logic                ready;
  brle_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/brle_out_if.sv =====
// valid/ready channel carrying one addressed write of the compressed row
// depends on: brle_pkg
interface brle_out_if;
  logic                valid;
  logic                ready;
  brle_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/brle_step.sv =====
// single-pass encode logic: next state and write list for one input item
// depends on: brle_pkg
module brle_step (
  input  brle_pkg::enc_state_t st_i,
  input  brle_pkg::in_item_t   item_i,
  output brle_pkg::enc_state_t st_o,
  output brle_pkg::step_out_t  res_o
);

  typedef struct packed {
    brle_pkg::enc_state_t                      st;
    brle_pkg::wr_t [brle_pkg::MAX_RESULTS-1:0] writes;
    logic [brle_pkg::RES_CNT_W-1:0]            count;
  } work_t;

  // append one write to the list
  function automatic work_t put(work_t w, logic [brle_pkg::OFF_W-1:0] off,
                                logic [7:0] b);
    if (w.count < brle_pkg::RES_CNT_W'(brle_pkg::MAX_RESULTS)) begin
      w.writes[w.count[brle_pkg::RES_IDX_W-1:0]] = '{offset: off, value: b};
      w.count = w.count + brle_pkg::RES_CNT_W'(1);
    end
    return w;
  endfunction

  // literal byte, closing the block when it is full
  function automatic work_t emit_literal(work_t w, logic [7:0] x);
    w = put(w, w.st.fill_position, x);
    w.st.fill_position = w.st.fill_position + brle_pkg::OFF_W'(1);
    w.st.literal_count = w.st.literal_count + 7'd1;
    if (w.st.literal_count > brle_pkg::RUN_CAP) begin
      w = put(w, w.st.count_slot, {1'b0, w.st.literal_count});
      w.st.count_slot    = w.st.fill_position;
      w.st.fill_position = w.st.fill_position + brle_pkg::OFF_W'(1);
      w.st.literal_count = 7'd0;
    end
    return w;
  endfunction

  // run token and value, closing any open literal block first
  function automatic work_t emit_run(work_t w, logic [6:0] len, logic [7:0] v);
    logic [brle_pkg::OFF_W-1:0] pos;
    pos = w.st.count_slot;
    if (w.st.literal_count != 7'd0) begin
      w   = put(w, w.st.count_slot, {1'b0, w.st.literal_count});
      pos = w.st.fill_position;
    end
    w = put(w, pos, brle_pkg::TOKEN_FLAG | {1'b0, len});
    w = put(w, pos + brle_pkg::OFF_W'(1), v);
    w.st.count_slot    = pos + brle_pkg::OFF_W'(2);
    w.st.fill_position = pos + brle_pkg::OFF_W'(3);
    w.st.literal_count = 7'd0;
    return w;
  endfunction

  // emit the gathered group as a run or as one or two literals
  function automatic work_t flush(work_t w);
    if (w.st.pending_run >= brle_pkg::RUN_MIN) begin
      w = emit_run(w, w.st.pending_run, w.st.pending_value);
    end else begin
      if (w.st.pending_run != 7'd0) w = emit_literal(w, w.st.pending_value);
      if (w.st.pending_run == 7'd2) w = emit_literal(w, w.st.pending_value);
    end
    w.st.pending_run = 7'd0;
    return w;
  endfunction

  work_t                      w;
  logic                       over;
  logic [brle_pkg::OFF_W-1:0] length;

  // one item through the encoder
  always_comb begin
    w.st     = st_i;
    w.writes = '0;
    w.count  = '0;
    length   = '0;

    if (w.st.bytes_seen <= brle_pkg::SEEN_W'(brle_pkg::ROW_BYTES)) begin
      w.st.bytes_seen = w.st.bytes_seen + brle_pkg::SEEN_W'(1);
    end
    over = w.st.bytes_seen > brle_pkg::SEEN_W'(brle_pkg::ROW_BYTES);

    // a different byte or a full run ends the current group
    if (w.st.pending_run != 7'd0 &&
        (item_i.data_byte != w.st.pending_value ||
         w.st.pending_run >= brle_pkg::RUN_CAP)) begin
      w = flush(w);
    end
    if (w.st.pending_run == 7'd0) w.st.pending_value = item_i.data_byte;
    w.st.pending_run = w.st.pending_run + 7'd1;

    // row end: flush, close the open block, report length, restart
    if (item_i.row_end) begin
      w = flush(w);
      if (w.st.literal_count != 7'd0) begin
        w      = put(w, w.st.count_slot, {1'b0, w.st.literal_count});
        length = w.st.fill_position;
      end else begin
        length = w.st.fill_position - brle_pkg::OFF_W'(1);
      end
      w.st = brle_pkg::ENC_RESET;
    end

    st_o             = w.st;
    res_o.writes     = w.writes;
    res_o.count      = w.count;
    res_o.overlong   = over;
    res_o.row_end    = item_i.row_end;
    res_o.row_length = length;
  end

endmodule

// ===== rtl/byte_run_length_encoder_unit.sv =====
// Byte run-length encoder for one image row. Each input item is one row byte; each result
// item is an addressed write into the compressed row buffer (literal, run token, run value
// or a literal block count written back into its reserved slot). The row's final write
// carries row_done and the compressed length. An accepted item is registered, encoded by
// single-pass logic and its writes (zero to five) are loaded, once the buffer is free,
// into a six-entry result buffer that drains one write per cycle while the output is
// ready. The input side takes one item per cycle while each item causes at most one write
// and the output is ready; an item causing several writes holds the result buffer, the
// single output port, until all of them have drained. Depends on brle_pkg, brle_in_if,
// brle_out_if, brle_step and the defines header.
`include "byte_run_length_encoder_unit_defines.svh"

module byte_run_length_encoder_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  brle_in_if.sink           in_i,
  brle_out_if.source        res_o
);

  // input register
  logic                 in_valid_q;
  brle_pkg::in_item_t   in_q;

  // encoder state
  brle_pkg::enc_state_t st_q;
  brle_pkg::enc_state_t st_d;
  brle_pkg::step_out_t  step;

  // result buffer
  brle_pkg::wr_t                    buf_q [brle_pkg::MAX_RESULTS];
  logic [brle_pkg::RES_CNT_W-1:0]   res_n_q;
  logic [brle_pkg::RES_CNT_W-1:0]   rd_idx_q;
  logic                             buf_over_q;
  logic                             buf_row_end_q;
  logic [brle_pkg::OFF_W-1:0]       buf_len_q;

  logic out_valid;
  logic out_take;
  logic out_last;
  logic buf_free;
  logic step_fire;
  brle_pkg::wr_t cur_wr;

  // buffer drain control
  assign out_valid = rd_idx_q != res_n_q;
  assign out_last  = rd_idx_q == (res_n_q - brle_pkg::RES_CNT_W'(1));
  assign out_take  = out_valid && res_o.ready;
  assign buf_free  = !out_valid || (out_take && out_last);
  assign step_fire = in_valid_q && buf_free;
  assign in_i.ready = !in_valid_q || step_fire;

  // input item register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
  end

  // encode logic
  brle_step u_step (
    .st_i   (st_q),
    .item_i (in_q),
    .st_o   (st_d),
    .res_o  (step)
  );

  // encoder state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= brle_pkg::ENC_RESET;
    end else if (step_fire) begin
      st_q <= st_d;
    end
  end

  // result buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_n_q  <= '0;
      rd_idx_q <= '0;
    end else if (step_fire) begin
      res_n_q  <= step.count;
      rd_idx_q <= '0;
    end else if (out_take) begin
      rd_idx_q <= rd_idx_q + brle_pkg::RES_CNT_W'(1);
    end
  end

  // result buffer payload
  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      for (int i = 0; i < brle_pkg::MAX_RESULTS; i++) begin
        buf_q[i] <= step.writes[i];
      end
      buf_over_q    <= step.overlong;
      buf_row_end_q <= step.row_end;
      buf_len_q     <= step.row_length;
    end
  end

  // output item
  assign cur_wr = buf_q[rd_idx_q[brle_pkg::RES_IDX_W-1:0]];

  always_comb begin
    res_o.valid             = out_valid;
    res_o.data.write_offset = cur_wr.offset;
    res_o.data.write_byte   = cur_wr.value;
    res_o.data.last_of_item = out_last;
    res_o.data.row_done     = out_last && buf_row_end_q;
    res_o.data.row_length   = (out_last && buf_row_end_q) ? buf_len_q : '0;
    res_o.data.overlong     = buf_over_q;
  end

  // checks
  `BRLE_ASSERT_NOW(a_buf_index,
    (res_n_q <= brle_pkg::RES_CNT_W'(brle_pkg::MAX_RESULTS)) && (rd_idx_q <= res_n_q))
  `BRLE_ASSERT_NOW(a_counts_capped,
    (st_q.pending_run <= brle_pkg::RUN_CAP) && (st_q.literal_count <= brle_pkg::RUN_CAP))
  `BRLE_ASSERT_NOW(a_done_is_last, !(res_o.valid && res_o.data.row_done) || res_o.data.last_of_item)
  `BRLE_ASSERT_NEXT(a_row_restart, step_fire && in_q.row_end, st_q == brle_pkg::ENC_RESET)

endmodule

// ===== verif/brle_write_check.sv =====
// write checker for the byte run-length encoder unit: watches both channels,
// predicts the addressed writes of every accepted byte and compares them in order
// depends on: brle_pkg, brle_in_if, brle_out_if
`timescale 1ns / 100ps

module brle_write_check
  import brle_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  brle_in_if   in_mon_i,
  brle_out_if  res_mon_i,
  output int   mismatches_o,
  output int   outstanding_o,
  output int   writes_checked_o
);

  // predicted encoder state
  logic [7:0]       run_value;
  int unsigned      run_len;
  int unsigned      block_literals;
  logic [OFF_W-1:0] count_offset;
  logic [OFF_W-1:0] next_offset;
  int unsigned      row_byte_count;

  // writes of the current byte, and all writes still due from the block
  out_item_t step_writes[$];
  out_item_t due_writes[$];

  out_item_t seen_write;
  out_item_t due_write;
  int        error_total;
  int        checked_total;

  task automatic clear_encoder();
    run_value      = '0;
    run_len        = 0;
    block_literals = 0;
    count_offset   = '0;
    next_offset    = OFF_W'(1);
    row_byte_count = 0;
  endtask

  task automatic add_write(input logic [OFF_W-1:0] offset, input logic [7:0] value);
    out_item_t w;
    w = '0;
    w.write_offset = offset;
    w.write_byte   = value;
    step_writes.push_back(w);
  endtask

  // emit the gathered group: a run token for three or more, else literals
  task automatic flush_group();
    logic [OFF_W-1:0] token_pos;
    if (run_len >= RUN_MIN) begin
      token_pos = count_offset;
      // close the open literal block first, token goes behind it
      if (block_literals > 0) begin
        add_write(count_offset, 8'(block_literals));
        token_pos = next_offset;
      end
      add_write(token_pos, TOKEN_FLAG | 8'(run_len));
      add_write(token_pos + OFF_W'(1), run_value);
      count_offset   = token_pos + OFF_W'(2);
      next_offset    = token_pos + OFF_W'(3);
      block_literals = 0;
    end else begin
      for (int k = 0; k < run_len; k++) begin
        add_write(next_offset, run_value);
        next_offset = next_offset + OFF_W'(1);
        block_literals++;
        // full block: write its count and reserve the next slot
        if (block_literals > RUN_CAP) begin
          add_write(count_offset, 8'(block_literals));
          count_offset   = next_offset;
          next_offset    = next_offset + OFF_W'(1);
          block_literals = 0;
        end
      end
    end
    run_len = 0;
  endtask

  // expected writes for one accepted byte
  task automatic predict_item(input in_item_t item);
    logic [OFF_W-1:0] compressed_len;
    logic             over;
    int               last_idx;
    compressed_len = '0;
    step_writes.delete();
    if (row_byte_count <= ROW_BYTES) row_byte_count++;
    over = (row_byte_count > ROW_BYTES);

    if (run_len != 0 && (item.data_byte != run_value || run_len >= RUN_CAP)) flush_group();
    if (run_len == 0) run_value = item.data_byte;
    run_len++;

    // row end flushes everything and closes the open block
    if (item.row_end) begin
      flush_group();
      if (block_literals > 0) begin
        add_write(count_offset, 8'(block_literals));
        compressed_len = next_offset;
      end else begin
        compressed_len = next_offset - OFF_W'(1);
      end
    end

    foreach (step_writes[k]) step_writes[k].overlong = over;
    if (step_writes.size() > 0) begin
      last_idx = step_writes.size() - 1;
      step_writes[last_idx].last_of_item = 1'b1;
      if (item.row_end) begin
        step_writes[last_idx].row_done   = 1'b1;
        step_writes[last_idx].row_length = compressed_len;
      end
    end
    foreach (step_writes[k]) due_writes.push_back(step_writes[k]);

    if (item.row_end) clear_encoder();
  endtask

  // predict on accepted bytes, compare accepted writes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_encoder();
      due_writes.delete();
      error_total   = 0;
      checked_total = 0;
      mismatches_o     <= 0;
      outstanding_o    <= 0;
      writes_checked_o <= 0;
    end else begin
      if (in_mon_i.valid && in_mon_i.ready) predict_item(in_mon_i.data);

      if (res_mon_i.valid && res_mon_i.ready) begin
        seen_write = res_mon_i.data;
        checked_total++;
        if (due_writes.size() == 0) begin
          $error("unexpected write: offset %0d byte %0d", seen_write.write_offset,
                 seen_write.write_byte);
          error_total++;
        end else begin
          due_write = due_writes.pop_front();
          if (seen_write.write_offset !== due_write.write_offset) begin
            $error("write_offset: expected %0d, got %0d", due_write.write_offset,
                   seen_write.write_offset);
            error_total++;
          end
          if (seen_write.write_byte !== due_write.write_byte) begin
            $error("write_byte: expected %0d, got %0d", due_write.write_byte,
                   seen_write.write_byte);
            error_total++;
          end
          if (seen_write.last_of_item !== due_write.last_of_item) begin
            $error("last_of_item: expected %0d, got %0d", due_write.last_of_item,
                   seen_write.last_of_item);
            error_total++;
          end
          if (seen_write.row_done !== due_write.row_done) begin
            $error("row_done: expected %0d, got %0d", due_write.row_done,
                   seen_write.row_done);
            error_total++;
          end
          if (seen_write.row_length !== due_write.row_length) begin
            $error("row_length: expected %0d, got %0d", due_write.row_length,
                   seen_write.row_length);
            error_total++;
          end
          if (seen_write.overlong !== due_write.overlong) begin
            $error("overlong: expected %0d, got %0d", due_write.overlong,
                   seen_write.overlong);
            error_total++;
          end
        end
      end

      mismatches_o     <= error_total;
      outstanding_o    <= due_writes.size();
      writes_checked_o <= checked_total;
    end
  end

endmodule

// ===== verif/testbench.sv =====
// top of the byte run-length encoder unit testbench: clock, reset, row stimulus,
// output stall pattern and the verdict
// depends on: brle_pkg, brle_in_if, brle_out_if, byte_run_length_encoder_unit, brle_write_check
`timescale 1ns / 100ps

module testbench;
  import brle_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int          RANDOM_BYTES = 100;

  typedef enum int {SINK_OPEN, SINK_MOSTLY, SINK_SPARSE, SINK_COIN} sink_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic       src_valid  = 1'b0;
  in_item_t   src_item   = '0;
  logic       sink_ready = 1'b0;

  int unsigned cycle_count = 0;
  int unsigned sink_tick   = 0;
  sink_mode_e  sink_mode   = SINK_OPEN;

  int burst_left   = 0;
  int bytes_sent   = 0;
  int rows_sent    = 0;
  int random_bytes = 0;
  int mismatches;
  int outstanding;
  int writes_checked;

  logic [7:0] row_bytes[$];

  brle_in_if  in_if ();
  brle_out_if res_if ();

  assign in_if.valid  = src_valid;
  assign in_if.data   = src_item;
  assign res_if.ready = sink_ready;

  byte_run_length_encoder_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .res_o  (res_if)
  );

  brle_write_check write_check_u (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon_i         (in_if),
    .res_mon_i        (res_if),
    .mismatches_o     (mismatches),
    .outstanding_o    (outstanding),
    .writes_checked_o (writes_checked)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("byte_run_length_encoder_unit verification failed");
      $finish;
    end
  end

  // output stall pattern, in modes chosen at random
  always @(posedge clk_i) begin
    sink_tick <= sink_tick + 1;
    if (sink_tick % 64 == 0) sink_mode <= sink_mode_e'($urandom_range(0, 3));
    case (sink_mode)
      SINK_OPEN:   sink_ready <= 1'b1;
      SINK_MOSTLY: sink_ready <= ($urandom_range(0, 3) != 0);
      SINK_SPARSE: sink_ready <= (sink_tick % 5 == 0);
      default:     sink_ready <= 1'($urandom_range(0, 1));
    endcase
  end

  // send the buffered row, row_end on its last byte, in bursts with gaps
  task automatic send_row();
    foreach (row_bytes[k]) begin
      if (burst_left == 0) begin
        src_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 12);
      end
      src_valid <= 1'b1;
      src_item  <= '{data_byte: row_bytes[k], row_end: (k == row_bytes.size() - 1)};
      @(posedge clk_i);
      while (!in_if.ready) @(posedge clk_i);
      burst_left--;
      bytes_sent++;
    end
    rows_sent++;
    row_bytes.delete();
  endtask

  task automatic add_run(input logic [7:0] value, input int count);
    repeat (count) row_bytes.push_back(value);
  endtask

  // bytes that never repeat their predecessor
  task automatic add_literals(input int count);
    logic [7:0] v;
    repeat (count) begin
      v = 8'($urandom_range(0, 255));
      if (row_bytes.size() > 0 && v == row_bytes[row_bytes.size() - 1]) v = v + 8'd1;
      row_bytes.push_back(v);
    end
  endtask

  // hold the input idle until every predicted write has come out
  task automatic wait_drained();
    src_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows: single byte, run at row end with no open block,
    // short groups, run behind literals, literal after a run
    row_bytes = '{8'h00};
    send_row();
    row_bytes = '{8'hFF, 8'hFF, 8'hFF};
    send_row();
    row_bytes = '{8'h55, 8'h55, 8'hAA, 8'hAA, 8'hAA, 8'h01};
    send_row();
    row_bytes = '{8'h80, 8'h7F, 8'h7F};
    send_row();
    row_bytes = '{8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'hF0};
    send_row();
    row_bytes = '{8'h01, 8'h02, 8'h03, 8'h03, 8'h03};
    send_row();
    wait_drained();

    // full literal block, run past the cap, then a run closing the row
    add_literals(122);
    add_run(8'($urandom_range(0, 255)), $urandom_range(121, 126));
    add_literals(1);
    add_run(8'($urandom_range(0, 255)), 3);
    send_row();

    // random rows built from weighted segments
    while (random_bytes < RANDOM_BYTES) begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: add_run(8'($urandom_range(0, 255)), $urandom_range(1, 4));
          4, 5:       add_run(8'($urandom_range(0, 255)), $urandom_range(3, 20));
          6, 7:       add_literals($urandom_range(1, 15));
          8: begin
            // two-value noise gives ragged groups of every short length
            logic [7:0] base;
            base = 8'($urandom_range(0, 255));
            repeat ($urandom_range(1, 20)) row_bytes.push_back(base ^ 8'($urandom_range(0, 1)));
          end
          default: begin
            if ($urandom_range(0, 1) == 1) add_run(8'($urandom_range(0, 255)),
                                                   $urandom_range(115, 125));
            else add_literals($urandom_range(115, 125));
          end
        endcase
      end
      // keep the total byte count near the target
      while (row_bytes.size() > RANDOM_BYTES - random_bytes) void'(row_bytes.pop_back());
      random_bytes += row_bytes.size();
      send_row();
    end

    // pause until the block has drained
    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("stimulus: %0d bytes in %0d rows, with capped runs, full literal blocks",
             bytes_sent, rows_sent);
    $display("and random rows of mixed runs and literals; %0d writes compared, %0d mismatches",
             writes_checked, mismatches);
    if (mismatches == 0) begin
      $display("byte_run_length_encoder_unit verification clean");
    end else begin
      $display("byte_run_length_encoder_unit verification failed");
    end
    $finish;
  end

endmodule
